// File: rtl/indexed_binary_search_macros.svh
// Assertion macros for the indexed binary search block.
`ifndef INDEXED_BINARY_SEARCH_MACROS_SVH
`define INDEXED_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define IBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibs assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define IBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibs assertion failed: next-cycle implication");

`else

`define IBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/ibs_pkg.sv
package ibs_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_BITS_DEF    = 32;
  localparam int POS_W           = 7;
  localparam int REC_W           = 8;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WAIT
  } state_t;

  // Table port strobes from the search control to the table memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: rtl/ibs_table.sv
module ibs_table #(
  parameter int TABLE_DEPTH = ibs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ibs_pkg::KEY_BITS_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  ibs_pkg::mem_ctl_t         mem_ctl,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]       wr_key,
  input  logic [ibs_pkg::POS_W-1:0] wr_pos,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]       rd_key,
  output logic [ibs_pkg::POS_W-1:0] rd_pos
);
  import ibs_pkg::*;

  localparam int WORD_W = KEY_BITS + POS_W;

  // One word per slot: key in the upper bits, record position below.
  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= {wr_key, wr_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_key = rd_q_r[WORD_W-1:POS_W];
  assign rd_pos = rd_q_r[POS_W-1:0];

endmodule

// File: rtl/ibs_search.sv
module ibs_search #(
  parameter int TABLE_DEPTH = ibs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ibs_pkg::KEY_BITS_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CNT_W-1:0]          count,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [ADDR_W-1:0]         in_slot,
  input  logic signed [KEY_BITS-1:0] in_entry_key,
  input  logic [ibs_pkg::POS_W-1:0] in_entry_position,
  input  logic signed [KEY_BITS-1:0] in_search_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [ibs_pkg::REC_W-1:0] out_record_number,
  output ibs_pkg::mem_ctl_t         mem_ctl,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [KEY_BITS-1:0]       wr_key,
  output logic [ibs_pkg::POS_W-1:0] wr_pos,
  output logic [ADDR_W-1:0]         rd_addr,
  input  logic [KEY_BITS-1:0]       rd_key,
  input  logic [ibs_pkg::POS_W-1:0] rd_pos
);
  import ibs_pkg::*;

  localparam int IW = CNT_W + 1;
  localparam logic signed [IW-1:0] ONE = IW'(1);

  state_t state_r, state_nxt;

  logic signed [KEY_BITS-1:0] key_r;
  logic signed [IW-1:0]       low_r, high_r, lo_sel, hi_sel, low_n, high_n, mid_ext;
  logic signed [IW:0]         sum_sel;
  logic [ADDR_W-1:0]          mid_r, mid_sel;

  logic                       accept, is_search, out_free;
  logic                       probe_eq, probe_gt, empty_n;
  logic                       finish, fin_found;
  logic [REC_W-1:0]           fin_rec;
  logic                       res_found_r;
  logic [REC_W-1:0]           res_rec_r;
  logic                       out_valid_r, out_found_r;
  logic [REC_W-1:0]           out_rec_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_search = (in_kind == KIND_SEARCH);
  assign out_free  = !out_valid_r || !out_stall;

  // Probe compare against the entry read on the previous cycle.
  assign probe_eq = ($signed(rd_key) == key_r);
  assign probe_gt = ($signed(rd_key) > key_r);
  assign mid_ext  = signed'(IW'(mid_r));
  assign low_n    = probe_gt ? low_r : (mid_ext + ONE);
  assign high_n   = probe_gt ? (mid_ext - ONE) : high_r;
  assign empty_n  = (low_n > high_n);

  // Interval for the next probe: fresh on accept, narrowed while probing.
  always_comb begin
    if (state_r == ST_IDLE) begin
      lo_sel = '0;
      hi_sel = signed'(IW'(count)) - ONE;
    end else begin
      lo_sel = low_n;
      hi_sel = high_n;
    end
  end

  assign sum_sel = {lo_sel[IW-1], lo_sel} + {hi_sel[IW-1], hi_sel};
  assign mid_sel = sum_sel[ADDR_W:1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_search) begin
          if (count == '0) begin
            state_nxt = out_free ? ST_IDLE : ST_WAIT;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (probe_eq || empty_n) begin
          state_nxt = out_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    finish        = 1'b0;
    fin_found     = 1'b0;
    fin_rec       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_search) begin
          mem_ctl.wr_en = (CNT_W'(in_slot) < CNT_W'(TABLE_DEPTH));
        end
        if (accept && is_search) begin
          if (count == '0) begin
            finish = 1'b1;
          end else begin
            mem_ctl.rd_en = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (probe_eq) begin
          finish    = 1'b1;
          fin_found = 1'b1;
          fin_rec   = REC_W'(rd_pos) + REC_W'(1);
        end else if (empty_n) begin
          finish = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
        end
      end
      ST_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = in_slot;
  assign wr_key  = in_entry_key;
  assign wr_pos  = in_entry_position;
  assign rd_addr = mid_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((finish || state_r == ST_WAIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_search) begin
      key_r <= in_search_key;
    end
    if (mem_ctl.rd_en) begin
      low_r  <= lo_sel;
      high_r <= hi_sel;
      mid_r  <= mid_sel;
    end
    if (finish) begin
      res_found_r <= fin_found;
      res_rec_r   <= fin_rec;
    end
    if (out_free) begin
      if (state_r == ST_WAIT) begin
        out_found_r <= res_found_r;
        out_rec_r   <= res_rec_r;
      end else if (finish) begin
        out_found_r <= fin_found;
        out_rec_r   <= fin_rec;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_record_number = out_rec_r;

endmodule

// File: rtl/indexed_binary_search.sv
// Load request: written to the table at the accepting edge, no result.
// Search request: accepted in idle, then one table read per probe (one memory read
// port, one probe per cycle), at most ceil(log2(TABLE_DEPTH+1)) probes: 8 at 128.
// Result registered at the last probe; the next request waits until the search is done.
// Reset (rst_n low, synchronous): control idle, output empty, entry_count 0;
// table contents are undefined until loaded and get no clearing pass.
`include "indexed_binary_search_macros.svh"

module indexed_binary_search #(
  parameter int TABLE_DEPTH = ibs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ibs_pkg::KEY_BITS_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: entry_count
  input  logic                       cfg_wr_en,
  input  logic [CNT_W-1:0]           cfg_wr_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [ADDR_W-1:0]          in_slot,
  input  logic signed [KEY_BITS-1:0] in_entry_key,
  input  logic [ibs_pkg::POS_W-1:0]  in_entry_position,
  input  logic signed [KEY_BITS-1:0] in_search_key,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [ibs_pkg::REC_W-1:0]  out_record_number
);
  import ibs_pkg::*;

  logic [CNT_W-1:0]    entry_count_r;
  logic [CNT_W-1:0]    count_sat;
  mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [KEY_BITS-1:0] wr_key, rd_key;
  logic [POS_W-1:0]    wr_pos, rd_pos;

  // Count register; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  // Clamp the searched range to the table depth.
  assign count_sat = (entry_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : entry_count_r;

  // Search control: accepts one request at a time, walks the interval and
  // owns the result register. Writes happen only on a load accept in idle,
  // reads only during a search, so the two never touch the table together.
  ibs_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_search (
    .clk               (clk),
    .rst_n             (rst_n),
    .count             (count_sat),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_entry_key      (in_entry_key),
    .in_entry_position (in_entry_position),
    .in_search_key     (in_search_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_record_number (out_record_number),
    .mem_ctl           (mem_ctl),
    .wr_addr           (wr_addr),
    .wr_key            (wr_key),
    .wr_pos            (wr_pos),
    .rd_addr           (rd_addr),
    .rd_key            (rd_key),
    .rd_pos            (rd_pos)
  );

  // Index table: key and position per slot, registered read.
  ibs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_pos  (wr_pos),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_pos  (rd_pos)
  );

  // A hit always carries a nonzero record number, a miss always zero.
  `IBS_ASSERT_IMPLY(a_hit_rec, clk, rst_n, out_valid && out_found, out_record_number != '0)
  `IBS_ASSERT_IMPLY(a_miss_rec, clk, rst_n, out_valid && !out_found, out_record_number == '0)
  // Table write and probe read never share a cycle.
  `IBS_ASSERT_IMPLY(a_no_rw_overlap, clk, rst_n, mem_ctl.wr_en, !mem_ctl.rd_en)
  // A load request never produces a result.
  `IBS_ASSERT_NEXT(a_load_silent, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_LOAD) && !out_valid, !out_valid)

endmodule

// File: test/tb_indexed_binary_search.sv
module tb_indexed_binary_search;
  timeunit 1ns;
  timeprecision 1ps;

  import ibs_pkg::*;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  // Cycles to let pass after the last result before touching entry_count.
  localparam int SETTLE_CYCLES  = 12;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int LONG_HOLD      = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 600;
  localparam int QUIET_AFTER    = 540;

  // One expected search answer.
  typedef struct packed {
    logic       found;
    logic [7:0] rec;
  } lookup_t;

  // One row of the directed table. cnt is the entry_count the row runs under;
  // typed rows carry an answer that is checked as written.
  typedef struct {
    int                 cnt;
    kind_t              kind;
    logic [6:0]         slot;
    logic signed [31:0] ekey;
    logic [6:0]         epos;
    logic signed [31:0] skey;
    bit                 typed;
    logic               found;
    logic [7:0]         rec;
  } probe_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_LOAD;
  logic [6:0]         in_slot = '0;
  logic signed [31:0] in_entry_key = '0;
  logic [6:0]         in_entry_position = '0;
  logic signed [31:0] in_search_key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;
  logic [7:0]         out_record_number;

  // Mirror of the index table and of entry_count, updated at each accepted load and each entry_count write.
  logic signed [31:0] index_keys_m [0:127];
  logic [6:0]         index_pos_m  [0:127];
  int                 entry_count_m;

  lookup_t pending_lookups [$];
  int      errors;
  int      items_sent;
  int      stalled_cycles;
  bit      quiet;
  bit      hold_off_req;

  // Directed rows: empty table, entry extremes, every search outcome, an
  // unsorted table where the probes miss a key that is present.
  probe_row_t dir_rows [0:18] = '{
    '{0, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   32'sd0,  1'b1, 1'b0, 8'd0},
    '{0, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MIN, 1'b1, 1'b0, 8'd0},
    '{0, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MAX, 1'b1, 1'b0, 8'd0},
    '{0, KIND_LOAD,   7'd0,   KEY_MIN, 7'd0,   32'sd0,  1'b0, 1'b0, 8'd0},
    '{0, KIND_LOAD,   7'd1,   -32'sd1, 7'd127, KEY_MAX, 1'b0, 1'b0, 8'd0},
    '{0, KIND_LOAD,   7'd2,   32'sd0,  7'd5,   KEY_MIN, 1'b0, 1'b0, 8'd0},
    '{0, KIND_LOAD,   7'd3,   KEY_MAX, 7'd126, -32'sd1, 1'b0, 1'b0, 8'd0},
    '{0, KIND_LOAD,   7'd127, 32'sd7,  7'd0,   32'sd0,  1'b0, 1'b0, 8'd0},
    '{4, KIND_SEARCH, 7'd127, KEY_MAX, 7'd127, KEY_MIN, 1'b1, 1'b1, 8'd1},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   -32'sd1, 1'b1, 1'b1, 8'd128},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   32'sd0,  1'b0, 1'b0, 8'd0},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MAX, 1'b1, 1'b1, 8'd127},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   32'sd1,  1'b0, 1'b0, 8'd0},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   -32'sd2, 1'b0, 1'b0, 8'd0},
    '{1, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MIN, 1'b1, 1'b1, 8'd1},
    '{1, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MAX, 1'b1, 1'b0, 8'd0},
    '{1, KIND_LOAD,   7'd1,   KEY_MAX, 7'd9,   32'sd0,  1'b0, 1'b0, 8'd0},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   32'sd0,  1'b0, 1'b0, 8'd0},
    '{4, KIND_SEARCH, 7'd0,   32'sd0,  7'd0,   KEY_MAX, 1'b0, 1'b0, 8'd0}
  };

  indexed_binary_search uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_entry_key     (in_entry_key),
    .in_entry_position(in_entry_position),
    .in_search_key    (in_search_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_record_number(out_record_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Binary search over the mirrored table, midpoint floor((low+high)/2),
  // with entry_count clamped to the table depth.
  function automatic lookup_t predict_lookup(logic signed [31:0] key);
    int      n;
    int      lo;
    int      hi;
    int      mid;
    lookup_t r;
    n = (entry_count_m > 128) ? 128 : entry_count_m;
    lo = 0;
    hi = n - 1;
    r = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (index_keys_m[mid] == key) begin
        r.found = 1'b1;
        r.rec = {1'b0, index_pos_m[mid]} + 8'd1;
        break;
      end
      if (index_keys_m[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return r;
  endfunction

  // Offer one request and hold it until accepted, then update the mirror or
  // queue the expected answer. Leaves in_valid high for a back-to-back request.
  task automatic issue_request(kind_t kind, logic [6:0] slot, logic signed [31:0] ekey,
                               logic [6:0] epos, logic signed [31:0] skey,
                               bit typed, lookup_t typed_res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_kind           <= kind;
    in_slot           <= slot;
    in_entry_key      <= ekey;
    in_entry_position <= epos;
    in_search_key     <= skey;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_LOAD) begin
      index_keys_m[slot] = ekey;
      index_pos_m[slot]  = epos;
    end else begin
      pending_lookups.push_back(typed ? typed_res : predict_lookup(skey));
    end
    items_sent++;
  endtask

  // Drain every pending answer, let the block settle, then write entry_count.
  task automatic set_entry_count(int value);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[7:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    entry_count_m = value;
  endtask

  // Load all 128 slots with ascending keys: either sparse steps spread over
  // the key range or dense steps (duplicates included) so near misses hit.
  task automatic fill_sorted_table();
    longint cur;
    bit     dense;
    dense = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) cur = -64'sd2147483648;
    else if (dense) cur = longint'($signed($urandom())) - 400;
    else cur = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
    if (cur < -64'sd2147483648) cur = -64'sd2147483648;
    for (int i = 0; i < 128; i++) begin
      if (i == 127 && $urandom_range(0, 2) == 0) cur = 64'sd2147483647;
      issue_request(KIND_LOAD, i[6:0], cur[31:0], 7'($urandom_range(0, 127)), $urandom(),
                    1'b0, '0);
      cur += dense ? longint'($urandom_range(0, 3)) : longint'($urandom_range(1, 1 << 24));
    end
  endtask

  // Random search key: mostly a stored key, else a neighbor, noise or an extreme.
  function automatic logic signed [31:0] pick_search_key();
    int                 n;
    int                 sel;
    logic signed [31:0] k;
    n = (entry_count_m > 128) ? 128 : entry_count_m;
    sel = $urandom_range(0, 9);
    k = $urandom();
    if (n > 0 && sel <= 7) begin
      k = index_keys_m[$urandom_range(0, n - 1)];
      if (sel == 6) k = k + 32'sd1;
      if (sel == 7) k = k - 32'sd1;
    end else if (sel == 9) begin
      k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    end
    return k;
  endfunction

  // Receiver: random short stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expected answer.
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result found=%0b record_number=%0d",
                 $time, out_found, out_record_number);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_found);
          errors++;
        end
        if (out_record_number !== want.rec) begin
          $display("%0t: record_number expected %0d actual %0d",
                   $time, want.rec, out_record_number);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int      phase;
    int      phase_len;
    int      sel;
    int      slot;
    lookup_t typed_res;
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    entry_count_m = 0;
    for (int i = 0; i < 128; i++) begin
      index_keys_m[i] = '0;
      index_pos_m[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; switch entry_count only where a row asks for a new one.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cnt != entry_count_m) set_entry_count(dir_rows[i].cnt);
      typed_res = {dir_rows[i].found, dir_rows[i].rec};
      issue_request(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].ekey, dir_rows[i].epos,
                    dir_rows[i].skey, dir_rows[i].typed, typed_res);
    end

    // Random phases: refill with sorted content every few phases while the
    // request budget allows, then search under a fresh entry_count with a
    // sprinkle of position rewrites and noise.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase % 3 == 0 && items_sent + 128 < ITEM_TARGET) fill_sorted_table();
      case (phase)
        0: set_entry_count(128);
        1: set_entry_count(255);
        2: set_entry_count(0);
        3: set_entry_count(1);
        4: set_entry_count(2);
        5: set_entry_count(127);
        default: begin
          sel = $urandom_range(0, 9);
          if (sel <= 6) set_entry_count($urandom_range(0, 128));
          else if (sel == 7) set_entry_count(128);
          else if (sel == 8) set_entry_count($urandom_range(129, 255));
          else set_entry_count($urandom_range(0, 3));
        end
      endcase
      // Hold the receiver off once while requests keep coming.
      if (phase == 1) hold_off_req = 1'b1;
      phase_len = $urandom_range(25, 50);
      for (int j = 0; j < phase_len && items_sent < ITEM_TARGET; j++) begin
        quiet = (items_sent >= QUIET_AFTER);
        sel = $urandom_range(0, 99);
        slot = $urandom_range(0, 127);
        if (sel < 5) begin
          // Rewrite a position under the same key: order is kept.
          issue_request(KIND_LOAD, slot[6:0], index_keys_m[slot], 7'($urandom_range(0, 127)),
                        $urandom(), 1'b0, '0);
        end else if (sel < 8) begin
          // Random key into a random slot: the table may go unsorted.
          issue_request(KIND_LOAD, slot[6:0], $urandom(), 7'($urandom_range(0, 127)),
                        $urandom(), 1'b0, '0);
        end else begin
          issue_request(KIND_SEARCH, slot[6:0], $urandom(), 7'($urandom_range(0, 127)),
                        pick_search_key(), 1'b0, '0);
        end
      end
      phase++;
    end

    // Drop valid, drain the remaining answers and let the block go quiet.
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: indexed_binary_search.f
+incdir+rtl
rtl/ibs_pkg.sv
rtl/ibs_table.sv
rtl/ibs_search.sv
rtl/indexed_binary_search.sv
test/tb_indexed_binary_search.sv
